// ----- rtl/hdpc_pkg.sv -----
// shared types and constants for the heater drive pattern controller
package hdpc_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int TICK_W = 16;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_ENABLE = 2'd1,
    ACT_DEMAND = 2'd2,
    ACT_ALARM  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_ALARM = 2'd1,
    MODE_IDLE  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_ALARM_BLIP = 3'd0,
    REG_ALARM_REST = 3'd1,
    REG_IDLE_WAIT  = 3'd2,
    REG_IDLE_PULSE = 3'd3,
    REG_IDLE_REST  = 3'd4
  } reg_index_t;

  localparam logic [TICK_W-1:0] ALARM_BLIP_RESET = 16'd500;
  localparam logic [TICK_W-1:0] ALARM_REST_RESET = 16'd28500;
  localparam logic [TICK_W-1:0] IDLE_WAIT_RESET  = 16'd30000;
  localparam logic [TICK_W-1:0] IDLE_PULSE_RESET = 16'd3000;
  localparam logic [TICK_W-1:0] IDLE_REST_RESET  = 16'd27000;

  typedef struct packed {
    logic [1:0] action;
    logic       value;
  } in_word_t;

  typedef struct packed {
    logic       heater_drive;
    logic [1:0] pattern;
  } out_word_t;

  typedef struct packed {
    logic [TICK_W-1:0] alarm_blip_ticks;
    logic [TICK_W-1:0] alarm_rest_ticks;
    logic [TICK_W-1:0] idle_wait_ticks;
    logic [TICK_W-1:0] idle_pulse_ticks;
    logic [TICK_W-1:0] idle_rest_ticks;
  } cfg_t;

endpackage

// ----- rtl/hdpc_regs.sv -----
// apb register file holding the phase length settings
module hdpc_regs
  import hdpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  logic       wr_en;
  reg_index_t idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_index_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarm_blip_ticks <= ALARM_BLIP_RESET;
      cfg.alarm_rest_ticks <= ALARM_REST_RESET;
      cfg.idle_wait_ticks  <= IDLE_WAIT_RESET;
      cfg.idle_pulse_ticks <= IDLE_PULSE_RESET;
      cfg.idle_rest_ticks  <= IDLE_REST_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_ALARM_BLIP: cfg.alarm_blip_ticks <= pwdata[TICK_W-1:0];
        REG_ALARM_REST: cfg.alarm_rest_ticks <= pwdata[TICK_W-1:0];
        REG_IDLE_WAIT:  cfg.idle_wait_ticks  <= pwdata[TICK_W-1:0];
        REG_IDLE_PULSE: cfg.idle_pulse_ticks <= pwdata[TICK_W-1:0];
        REG_IDLE_REST:  cfg.idle_rest_ticks  <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_ALARM_BLIP: prdata[TICK_W-1:0] = cfg.alarm_blip_ticks;
      REG_ALARM_REST: prdata[TICK_W-1:0] = cfg.alarm_rest_ticks;
      REG_IDLE_WAIT:  prdata[TICK_W-1:0] = cfg.idle_wait_ticks;
      REG_IDLE_PULSE: prdata[TICK_W-1:0] = cfg.idle_pulse_ticks;
      REG_IDLE_REST:  prdata[TICK_W-1:0] = cfg.idle_rest_ticks;
      default:        prdata = '0;
    endcase
  end

endmodule

// ----- rtl/heater_drive_pattern_controller.sv -----
// top level: flag state, phase countdown and result register
//
// usage
//   input channel (in_valid/in_ready/in_word): one word per tick or flag change;
//   action 0 is a one-millisecond tick, 1/2/3 set enable/demand/alarm to value
//   output channel (out_valid/out_ready/out_word): one word per input word with
//   the heater level and the active timed pattern after that input
//   apb port: five 16-bit phase lengths at byte addresses 0, 4, 8, 12, 16;
//   pready is tied high, writes land at the access cycle; program only when idle
// latency and throughput
//   the result appears one cycle after the input word is taken; the flag and
//   countdown update is a single cycle of logic, so one word is taken per cycle
// reset
//   rst is synchronous and active high; all flags, the countdown and the output
//   level clear, no pattern is active, and registers return to their defaults
// stalls
//   the result register holds while out_ready is low, and in_ready drops with it;
//   a new word is taken in the same cycle that the held result is taken
module heater_drive_pattern_controller
  import hdpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  logic              enabled_flag, enabled_flag_next;
  logic              demand_flag, demand_flag_next;
  logic              alarm_flag, alarm_flag_next;
  logic              drive_level, drive_level_next;
  mode_t             pattern_mode, pattern_mode_next;
  logic [1:0]        phase_step, phase_step_next;
  logic [TICK_W-1:0] ticks_left, ticks_left_next;
  logic              restart;
  logic [1:0]        step_inc;
  logic              accept;

  assign pready   = 1'b1;
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign step_inc = phase_step + 2'd1;

  hdpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  always_comb begin
    enabled_flag_next = enabled_flag;
    demand_flag_next  = demand_flag;
    alarm_flag_next   = alarm_flag;
    drive_level_next  = drive_level;
    pattern_mode_next = pattern_mode;
    phase_step_next   = phase_step;
    ticks_left_next   = ticks_left;
    restart           = 1'b0;
    case (action_t'(in_word.action))
      ACT_TICK: begin
        if (pattern_mode != MODE_NONE) begin
          if (ticks_left <= 16'd1) begin
            if (pattern_mode == MODE_ALARM) begin
              phase_step_next  = step_inc;
              drive_level_next = !step_inc[0];
              ticks_left_next  = (step_inc == 2'd3) ? cfg.alarm_rest_ticks
                                                    : cfg.alarm_blip_ticks;
            end else if (phase_step == 2'd1) begin
              phase_step_next  = 2'd2;
              drive_level_next = 1'b0;
              ticks_left_next  = cfg.idle_rest_ticks;
            end else begin
              phase_step_next  = 2'd1;
              drive_level_next = 1'b1;
              ticks_left_next  = cfg.idle_pulse_ticks;
            end
          end else begin
            ticks_left_next = ticks_left - 16'd1;
          end
        end
      end
      ACT_ENABLE: begin
        if (enabled_flag != in_word.value) begin
          enabled_flag_next = in_word.value;
          restart           = 1'b1;
        end
      end
      ACT_DEMAND: begin
        if (demand_flag != in_word.value) begin
          demand_flag_next = in_word.value;
          restart          = !alarm_flag;
        end
      end
      ACT_ALARM: begin
        if (alarm_flag != in_word.value) begin
          alarm_flag_next = in_word.value;
          restart         = 1'b1;
        end
      end
      default: ;
    endcase
    if (restart) begin
      phase_step_next = 2'd0;
      ticks_left_next = '0;
      if (!enabled_flag_next) begin
        drive_level_next  = 1'b0;
        pattern_mode_next = MODE_NONE;
      end else if (alarm_flag_next) begin
        drive_level_next  = 1'b1;
        pattern_mode_next = MODE_ALARM;
        ticks_left_next   = cfg.alarm_blip_ticks;
      end else if (demand_flag_next) begin
        drive_level_next  = 1'b1;
        pattern_mode_next = MODE_NONE;
      end else begin
        drive_level_next  = 1'b0;
        pattern_mode_next = MODE_IDLE;
        ticks_left_next   = cfg.idle_wait_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_flag <= 1'b0;
      demand_flag  <= 1'b0;
      alarm_flag   <= 1'b0;
      drive_level  <= 1'b0;
      pattern_mode <= MODE_NONE;
      phase_step   <= 2'd0;
      ticks_left   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        enabled_flag <= enabled_flag_next;
        demand_flag  <= demand_flag_next;
        alarm_flag   <= alarm_flag_next;
        drive_level  <= drive_level_next;
        pattern_mode <= pattern_mode_next;
        phase_step   <= phase_step_next;
        ticks_left   <= ticks_left_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word.heater_drive <= drive_level_next;
      out_word.pattern      <= pattern_mode_next;
    end
  end

  a_none_no_count: assert property (@(posedge clk) disable iff (rst)
    pattern_mode == MODE_NONE |-> ticks_left == '0)
    else $error("countdown running with no pattern");

  a_alarm_level: assert property (@(posedge clk) disable iff (rst)
    pattern_mode == MODE_ALARM |-> drive_level == !phase_step[0])
    else $error("alarm level does not match phase");

  a_idle_level: assert property (@(posedge clk) disable iff (rst)
    pattern_mode == MODE_IDLE |-> drive_level == (phase_step == 2'd1))
    else $error("idle level does not match phase");

  a_disabled_low: assert property (@(posedge clk) disable iff (rst)
    !enabled_flag |-> (!drive_level && pattern_mode == MODE_NONE))
    else $error("output active while disabled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_valid && out_word.heater_drive == drive_level
                && out_word.pattern == pattern_mode))
    else $error("result word does not match state");

endmodule

// ----- tb/tb_heater_drive_pattern_controller.sv -----
// self-checking testbench for the heater drive pattern controller
module tb_heater_drive_pattern_controller;
  import hdpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  in_word_t          in_word;
  logic              out_valid;
  logic              out_ready;
  out_word_t         out_word;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  heater_drive_pattern_controller dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted controller state and phase lengths
  logic              h_en;
  logic              h_dem;
  logic              h_alm;
  logic              h_lvl;
  mode_t             h_mode;
  logic [1:0]        h_step;
  logic [TICK_W-1:0] h_left;
  cfg_t              h_cfg;

  out_word_t drive_expected[$];

  int  err_count      = 0;
  int  mismatch_count = 0;
  int  words_checked  = 0;
  int  words_sent     = 0;
  int  settings_count = 0;
  int  sink_hold      = 0;
  int  longest_hold   = 0;
  bit  no_idle        = 1'b0;

  function automatic void heater_reset();
    h_en   = 1'b0;
    h_dem  = 1'b0;
    h_alm  = 1'b0;
    h_lvl  = 1'b0;
    h_mode = MODE_NONE;
    h_step = 2'd0;
    h_left = '0;
    h_cfg.alarm_blip_ticks = ALARM_BLIP_RESET;
    h_cfg.alarm_rest_ticks = ALARM_REST_RESET;
    h_cfg.idle_wait_ticks  = IDLE_WAIT_RESET;
    h_cfg.idle_pulse_ticks = IDLE_PULSE_RESET;
    h_cfg.idle_rest_ticks  = IDLE_REST_RESET;
  endfunction

  function automatic void heater_restart();
    h_step = 2'd0;
    h_left = '0;
    if (!h_en) begin
      h_lvl  = 1'b0;
      h_mode = MODE_NONE;
    end else if (h_alm) begin
      h_lvl  = 1'b1;
      h_mode = MODE_ALARM;
      h_left = h_cfg.alarm_blip_ticks;
    end else if (h_dem) begin
      h_lvl  = 1'b1;
      h_mode = MODE_NONE;
    end else begin
      h_lvl  = 1'b0;
      h_mode = MODE_IDLE;
      h_left = h_cfg.idle_wait_ticks;
    end
  endfunction

  function automatic void heater_advance();
    if (h_mode == MODE_ALARM) begin
      h_step = h_step + 2'd1;
      h_lvl  = ~h_step[0];
      h_left = (h_step == 2'd3) ? h_cfg.alarm_rest_ticks : h_cfg.alarm_blip_ticks;
    end else if (h_step == 2'd1) begin
      h_step = 2'd2;
      h_lvl  = 1'b0;
      h_left = h_cfg.idle_rest_ticks;
    end else begin
      h_step = 2'd1;
      h_lvl  = 1'b1;
      h_left = h_cfg.idle_pulse_ticks;
    end
  endfunction

  function automatic out_word_t heater_predict(in_word_t w);
    out_word_t r;
    case (action_t'(w.action))
      ACT_TICK: begin
        if (h_mode == MODE_ALARM || h_mode == MODE_IDLE) begin
          if (h_left <= 16'd1) heater_advance();
          else h_left = h_left - 16'd1;
        end
      end
      ACT_ENABLE: begin
        if (h_en != w.value) begin
          h_en = w.value;
          heater_restart();
        end
      end
      ACT_DEMAND: begin
        if (h_dem != w.value) begin
          h_dem = w.value;
          if (!h_alm) heater_restart();
        end
      end
      default: begin
        if (h_alm != w.value) begin
          h_alm = w.value;
          heater_restart();
        end
      end
    endcase
    r.heater_drive = h_lvl;
    r.pattern      = h_mode;
    return r;
  endfunction

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
  endfunction

  function automatic logic [TICK_W-1:0] rand_len(int lo, int hi);
    return TICK_W'($urandom_range(lo, hi));
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       r;
    r = $urandom_range(0, 99);
    w.value = 1'($urandom_range(0, 1));
    if (r < 60) begin
      w.action = ACT_TICK;
    end else if (r < 70) begin
      w.action = ACT_ENABLE;
      w.value  = ($urandom_range(0, 9) != 0);
    end else if (r < 85) begin
      w.action = ACT_DEMAND;
    end else begin
      w.action = ACT_ALARM;
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int g;
    g = draw_gap();
    repeat (g) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    drive_expected.push_back(heater_predict(w));
    words_sent++;
  endtask

  task automatic send_action(action_t a, logic v);
    in_word_t w;
    w.action = a;
    w.value  = v;
    send_word(w);
  endtask

  task automatic send_random(int n);
    repeat (n) send_word(random_word());
  endtask

  // stop offering words and let every result come back
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_expected.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(reg_index_t idx, logic [TICK_W-1:0] v);
    logic [15:0] junk;
    junk    = 16'($urandom_range(0, 65535));
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= {junk, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ALARM_BLIP: h_cfg.alarm_blip_ticks = v;
      REG_ALARM_REST: h_cfg.alarm_rest_ticks = v;
      REG_IDLE_WAIT:  h_cfg.idle_wait_ticks  = v;
      REG_IDLE_PULSE: h_cfg.idle_pulse_ticks = v;
      default:        h_cfg.idle_rest_ticks  = v;
    endcase
  endtask

  task automatic program_phases(logic [TICK_W-1:0] blip, logic [TICK_W-1:0] arest,
                                logic [TICK_W-1:0] wait_len, logic [TICK_W-1:0] pulse,
                                logic [TICK_W-1:0] irest);
    settle_idle();
    apb_write(REG_ALARM_BLIP, blip);
    apb_write(REG_ALARM_REST, arest);
    apb_write(REG_IDLE_WAIT, wait_len);
    apb_write(REG_IDLE_PULSE, pulse);
    apb_write(REG_IDLE_REST, irest);
    settings_count++;
  endtask

  task automatic test_tick_and_flags();
    send_action(ACT_TICK, 1'b1);
    send_action(ACT_ENABLE, 1'b0);
    send_action(ACT_ENABLE, 1'b1);
    send_action(ACT_TICK, 1'b0);
    send_action(ACT_TICK, 1'b1);
    send_action(ACT_ALARM, 1'b1);
    send_action(ACT_DEMAND, 1'b1);
    send_action(ACT_TICK, 1'b0);
    send_action(ACT_ALARM, 1'b0);
    send_action(ACT_DEMAND, 1'b1);
    send_action(ACT_DEMAND, 1'b0);
    send_action(ACT_ENABLE, 1'b0);
    send_action(ACT_DEMAND, 1'b1);
    send_action(ACT_ALARM, 1'b1);
    send_action(ACT_ALARM, 1'b0);
    send_action(ACT_DEMAND, 1'b0);
  endtask

  task automatic test_zero_length_phases();
    program_phases(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_action(ACT_ENABLE, 1'b1);
    repeat (3) send_action(ACT_TICK, 1'b0);
    send_action(ACT_ALARM, 1'b1);
    repeat (5) send_action(ACT_TICK, 1'b1);
  endtask

  task automatic test_unit_phases();
    program_phases(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    send_random(100);
  endtask

  task automatic test_short_phases_with_stall();
    program_phases(rand_len(1, 8), rand_len(1, 8), rand_len(1, 8),
                   rand_len(1, 8), rand_len(1, 8));
    send_random(20);
    sink_hold    = 200;
    longest_hold = 200;
    send_random(130);
  endtask

  task automatic test_zero_phases_random();
    program_phases(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_random(80);
  endtask

  task automatic test_mixed_phases_no_gaps();
    program_phases(rand_len(0, 12), rand_len(0, 12), rand_len(0, 12),
                   rand_len(0, 12), rand_len(0, 12));
    no_idle = 1'b1;
    send_random(80);
    no_idle = 1'b0;
    send_random(70);
  endtask

  task automatic test_max_phases();
    program_phases(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_random(40);
  endtask

  task automatic test_default_lengths();
    program_phases(ALARM_BLIP_RESET, ALARM_REST_RESET, IDLE_WAIT_RESET,
                   IDLE_PULSE_RESET, IDLE_REST_RESET);
    send_random(30);
  endtask

  // receiver: random hold-off before each word, or a long one on request
  initial begin : output_sink
    int g;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        g = sink_hold;
        sink_hold = 0;
      end else begin
        g = draw_gap();
      end
      repeat (g) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (drive_expected.size() == 0) begin
        err_count++;
        $display("unexpected result word: drive %0b pattern %0d",
                 out_word.heater_drive, out_word.pattern);
      end else begin
        want = drive_expected.pop_front();
        words_checked++;
        if (out_word.heater_drive !== want.heater_drive || out_word.pattern !== want.pattern)
        begin
          err_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at word %0d: drive exp %0b got %0b, pattern exp %0d got %0d",
                     words_checked, want.heater_drive, out_word.heater_drive,
                     want.pattern, out_word.pattern);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_word   <= '0;
    out_ready <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    heater_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_tick_and_flags();
    test_zero_length_phases();
    test_unit_phases();
    test_short_phases_with_stall();
    test_zero_phases_random();
    test_mixed_phases_no_gaps();
    test_max_phases();
    test_default_lengths();

    settle_idle();
    repeat (5) @(posedge clk);
    if (drive_expected.size() != 0) begin
      err_count++;
      $display("%0d result words never arrived", drive_expected.size());
    end
    $display("sent %0d words, checked %0d results over %0d phase-length settings",
             words_sent, words_checked, settings_count + 1);
    $display("included zero, unit and full-scale lengths and a %0d-cycle output stall",
             longest_hold);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hdpc_pkg.sv
rtl/hdpc_regs.sv
rtl/heater_drive_pattern_controller.sv
tb/tb_heater_drive_pattern_controller.sv
